FILE: rtl/plf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptual light fade package
// Shared widths, payload and control types, and the inverse CIE lightness
// duty table used by the fade datapath.
// ----------------------------------------------------------------------------
package plf_pkg;

  // Field widths of the input and result transactions.
  localparam int TARGET_W = 8;
  localparam int DUR_W    = 16;
  localparam int LEVEL_W  = 7;
  localparam int DUTY_W   = 12;
  localparam int WAIT_W   = 13;
  localparam int STATUS_W = 2;

  // Fade constants.
  localparam int MAX_STEPS_DEF = 32;
  localparam int MIN_STEPS     = 8;
  localparam int FULL_PERCENT  = 100;
  localparam longint unsigned DUTY_FULL = 4095;
  localparam longint unsigned TOE_LIMIT = 8;
  localparam longint unsigned TOE_HALF  = 451;
  localparam longint unsigned TOE_DIV   = 903;
  localparam longint unsigned CUBE_DIV  = 116 * 116 * 116;
  localparam int LEVEL_ENTRIES = 2 ** LEVEL_W;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_STEP      = 2'd0,
    STATUS_NO_CHANGE = 2'd1,
    STATUS_REFUSED   = 2'd2
  } status_e;

  typedef struct packed {
    logic [TARGET_W-1:0] target_percent;
    logic [DUR_W-1:0]    duration_ms;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level_percent;
    logic [DUTY_W-1:0]   duty;
    logic                pwm_enable;
    logic [WAIT_W-1:0]   wait_ms;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic div_step;
    logic advance;
    logic norm;
    logic push;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    status_e kind;
    logic    div_done;
    logic    norm_needed;
    logic    last_step;
  } ctrl_sts_t;

  // Builds the duty table at elaboration: linear toe up to 8 %, rounded cube
  // above it, and zero for level zero and for codes above full scale.
  function automatic logic [LEVEL_ENTRIES*DUTY_W-1:0] build_duty_rom();
    logic [LEVEL_ENTRIES*DUTY_W-1:0] rom;
    longint unsigned v;
    longint unsigned val;
    rom = '0;
    for (int p = 1; p <= FULL_PERCENT; p++) begin
      if (longint'(p) <= TOE_LIMIT) begin
        val = (longint'(p) * DUTY_FULL + TOE_HALF) / TOE_DIV;
      end else begin
        v   = longint'(p) + 16;
        val = (DUTY_FULL * v * v * v + CUBE_DIV / 2) / CUBE_DIV;
      end
      rom[p*DUTY_W +: DUTY_W] = DUTY_W'(val);
    end
    return rom;
  endfunction

  localparam logic [LEVEL_ENTRIES*DUTY_W-1:0] DUTY_ROM = build_duty_rom();

  // Duty for one brightness level.
  function automatic logic [DUTY_W-1:0] duty_lookup(logic [LEVEL_W-1:0] level);
    return DUTY_ROM[int'(level)*DUTY_W +: DUTY_W];
  endfunction

endpackage

FILE: rtl/plf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptual light fade stream interface
// Valid/ready channel carrying one payload of the given type per transaction.
// ----------------------------------------------------------------------------
interface plf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/plf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptual light fade datapath
// Holds the request, the current level, the wait divider, the step quotient
// tracker and the result register.
// ----------------------------------------------------------------------------
module plf_datapath #(
  parameter int MAX_STEPS = plf_pkg::MAX_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plf_pkg::ctrl_cmd_t  cmd_i,
  output plf_pkg::ctrl_sts_t  sts_o,
  input  plf_pkg::in_t        in_data_i,
  input  logic                light_ready_we_i,
  input  logic                light_ready_i,
  output plf_pkg::out_t       out_data_o
);

  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int RW    = $clog2(MAX_STEPS + plf_pkg::FULL_PERCENT + 1);
  localparam int CNT_W = $clog2(plf_pkg::DUR_W + 1);
  localparam int LW    = plf_pkg::LEVEL_W;
  localparam logic [LW-1:0] FULL_LVL = LW'(plf_pkg::FULL_PERCENT);

  // Control state.
  logic          light_ready_q;
  logic [LW-1:0] current_level_q;

  // Request and fade working registers.
  logic [LW-1:0]            target_q;
  logic [plf_pkg::DUR_W-1:0] duration_q;
  plf_pkg::status_e         kind_q;
  logic [LW-1:0]            start_q;
  logic [LW-1:0]            mag_q;
  logic                     up_q;
  logic [SW-1:0]            steps_q;
  logic [SW-1:0]            k_q;
  logic [LW-1:0]            q_q;
  logic [RW-1:0]            r_q;
  logic [SW-1:0]            div_rem_q;
  logic [plf_pkg::DUR_W-1:0] div_quo_q;
  logic [CNT_W-1:0]         div_cnt_q;
  plf_pkg::out_t            out_q;

  // Decision logic on the captured request.
  logic [LW-1:0]     start_c;
  logic [LW-1:0]     mag_c;
  logic              up_c;
  logic [SW-1:0]     steps_c;
  plf_pkg::status_e  kind_c;

  always_comb begin
    start_c = (current_level_q > FULL_LVL) ? FULL_LVL : current_level_q;
    up_c    = target_q > start_c;
    mag_c   = up_c ? (target_q - start_c) : (start_c - target_q);
    if (mag_c < LW'(plf_pkg::MIN_STEPS)) begin
      steps_c = SW'(plf_pkg::MIN_STEPS);
    end else if ({1'b0, mag_c} > 8'(MAX_STEPS)) begin
      steps_c = SW'(MAX_STEPS);
    end else begin
      steps_c = SW'(mag_c);
    end
    if (!light_ready_q) begin
      kind_c = plf_pkg::STATUS_REFUSED;
    end else if (target_q == start_c) begin
      kind_c = plf_pkg::STATUS_NO_CHANGE;
    end else begin
      kind_c = plf_pkg::STATUS_STEP;
    end
  end

  // One restoring divider step for the per-step wait.
  logic [SW:0]   div_trial;
  logic          div_fit;
  logic [SW-1:0] div_rem_d;

  always_comb begin
    div_trial = {div_rem_q, div_quo_q[plf_pkg::DUR_W-1]};
    div_fit   = div_trial >= {1'b0, steps_q};
    div_rem_d = div_fit ? SW'(div_trial - {1'b0, steps_q}) : div_trial[SW-1:0];
  end

  // Level of the current step.
  logic [LW:0]   up_sum;
  logic [LW-1:0] step_level;
  logic          last_step;
  plf_pkg::out_t result_c;

  always_comb begin
    up_sum    = {1'b0, start_q} + {1'b0, q_q};
    last_step = k_q == steps_q;
    if (up_q) begin
      step_level = (up_sum > {1'b0, FULL_LVL}) ? FULL_LVL : up_sum[LW-1:0];
    end else begin
      step_level = (q_q > start_q) ? '0 : (start_q - q_q);
    end

    result_c        = '0;
    result_c.status = kind_q;
    result_c.last   = 1'b1;
    case (kind_q)
      plf_pkg::STATUS_STEP: begin
        result_c.level_percent = step_level;
        result_c.last          = last_step;
        result_c.wait_ms       = last_step ? '0 : div_quo_q[plf_pkg::WAIT_W-1:0];
      end
      plf_pkg::STATUS_NO_CHANGE: begin
        result_c.level_percent = start_q;
      end
      default: begin
        result_c.level_percent = '0;
      end
    endcase
    result_c.duty       = plf_pkg::duty_lookup(result_c.level_percent);
    result_c.pwm_enable = result_c.level_percent != '0;
  end

  // Configuration register and current level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_ready_q   <= 1'b0;
      current_level_q <= '0;
    end else begin
      if (light_ready_we_i) begin
        light_ready_q <= light_ready_i;
      end
      if (cmd_i.push && (kind_q == plf_pkg::STATUS_STEP)) begin
        current_level_q <= step_level;
      end
    end
  end

  // Working registers, sequenced by the controller.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      target_q   <= (in_data_i.target_percent > 8'(plf_pkg::FULL_PERCENT)) ?
                    FULL_LVL : in_data_i.target_percent[LW-1:0];
      duration_q <= in_data_i.duration_ms;
    end
    if (cmd_i.decide) begin
      kind_q    <= kind_c;
      start_q   <= start_c;
      mag_q     <= mag_c;
      up_q      <= up_c;
      steps_q   <= steps_c;
      k_q       <= '0;
      q_q       <= '0;
      r_q       <= RW'(steps_c >> 1);
      div_rem_q <= '0;
      div_quo_q <= duration_q;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_rem_q <= div_rem_d;
      div_quo_q <= {div_quo_q[plf_pkg::DUR_W-2:0], div_fit};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.advance) begin
      r_q <= r_q + RW'(mag_q);
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.norm) begin
      r_q <= r_q - RW'(steps_q);
      q_q <= q_q + 1'b1;
    end
    if (cmd_i.push) begin
      out_q <= result_c;
    end
  end

  always_comb begin
    sts_o.kind        = kind_c;
    sts_o.div_done    = div_cnt_q == CNT_W'(plf_pkg::DUR_W);
    sts_o.norm_needed = r_q >= RW'(steps_q);
    sts_o.last_step   = (kind_q != plf_pkg::STATUS_STEP) || last_step;
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/plf_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptual light fade controller
// Sequences capture, decision, wait division, step advance and result hand-off.
// ----------------------------------------------------------------------------
module plf_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  plf_pkg::ctrl_sts_t sts_i,
  output plf_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_ADV,
    S_NORM,
    S_PUSH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.decide   = state_q == S_DECIDE;
    cmd_o.div_step = (state_q == S_DIV) && !sts_i.div_done;
    cmd_o.advance  = state_q == S_ADV;
    cmd_o.norm     = (state_q == S_NORM) && sts_i.norm_needed;
    cmd_o.push     = (state_q == S_PUSH) && slot_free;
  end

  // State and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= (sts_i.kind == plf_pkg::STATUS_STEP) ? S_DIV : S_PUSH;
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_ADV;
          end
        end
        S_ADV: begin
          state_q <= S_NORM;
        end
        S_NORM: begin
          if (!sts_i.norm_needed) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (slot_free) begin
            state_q <= sts_i.last_step ? S_IDLE : S_ADV;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/perceptual_light_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptual light fade
// Fades a light from its current percent to a requested percent, giving one
// result transaction per step with level, CIE lightness duty and wait.
// ----------------------------------------------------------------------------
// A fade request is taken only while no earlier request is being worked on.
// A refused or no-change request passes from capture through the decide
// state to the push state, which registers its single result; the next
// request can be taken once that push is done. A fade first runs a 16-step
// restoring divider for the wait, then passes for each step through the
// advance, normalise and push states. The normaliser is single-subtract and
// subtracts once for every unit the step quotient advances. A stall on the
// result channel holds the fade in its push state. One finished result may
// wait in the output register while the next request is accepted.
module perceptual_light_fade #(
  parameter int MAX_STEPS = plf_pkg::MAX_STEPS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  light_ready_we_i,
  input  logic  light_ready_i,
  plf_stream_if.sink   in_i,
  plf_stream_if.source out_o
);

  plf_pkg::ctrl_cmd_t cmd;
  plf_pkg::ctrl_sts_t sts;

  // Sequencer.
  plf_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  plf_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_data_i        (in_i.data),
    .light_ready_we_i (light_ready_we_i),
    .light_ready_i    (light_ready_i),
    .out_data_o       (out_o.data)
  );

endmodule

FILE: rtl/plf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptual light fade checker
// Port-level assertions on the result channel of the fade block.
// ----------------------------------------------------------------------------
module plf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input plf_pkg::out_t out_data_i
);

  // A refused request yields a single blank result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == plf_pkg::STATUS_REFUSED) |->
      out_data_i.last && (out_data_i.level_percent == '0) && !out_data_i.pwm_enable)
    else $error("refused result is not a blank final transaction");

  // PWM is enabled exactly when the level is nonzero, and level zero has no duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.pwm_enable == (out_data_i.level_percent != '0)) &&
      ((out_data_i.level_percent != '0) || (out_data_i.duty == '0)))
    else $error("pwm enable or duty disagrees with level");

  // The final result of a request carries no wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.last |-> out_data_i.wait_ms == '0)
    else $error("final result has a nonzero wait");

  // A stalled result transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

endmodule

bind perceptual_light_fade plf_checker u_plf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
